// ----- hw/rtl/variable_width_crc_engine_unit_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the variable-width CRC engine
// Shared checking helpers, clocked and gated by an active-low reset.
// ---------------------------------------------------------------------------
`ifndef VARIABLE_WIDTH_CRC_ENGINE_UNIT_MACROS_SVH
`define VARIABLE_WIDTH_CRC_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication.
`define VWCRC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vwcrc check failed (same cycle)");

// Next-cycle implication.
`define VWCRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vwcrc check failed (next cycle)");

`endif

// ----- hw/rtl/vwcrc_pkg.sv -----
// ---------------------------------------------------------------------------
// vwcrc_pkg
// Types, register indexes and helpers shared by the CRC engine modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package vwcrc_pkg;

    localparam int CrcBits = 32;
    localparam int CntBits = 6;

    // Configuration register indexes.
    localparam logic CFG_POLYNOMIAL = 1'b0;
    localparam logic CFG_CRC_WIDTH  = 1'b1;

    localparam logic [CrcBits-1:0] POLY_RESET  = 32'h04C1_1DB7;
    localparam logic [CntBits-1:0] WIDTH_RESET = 6'd32;

    typedef struct packed {
        logic [CrcBits-1:0] poly_aligned;
    } cfg_t;

    typedef struct packed {
        logic               first;
        logic [CrcBits-1:0] seed;
        logic [CrcBits-1:0] data_word;
        logic [CntBits-1:0] nbits;
    } item_t;

    // Left-aligns the polynomial at the top of the 32-bit register.
    // Width zero acts as one, widths above 32 act as 32.
    function automatic logic [CrcBits-1:0] align_poly(
        input logic [CrcBits-1:0] poly,
        input logic [CntBits-1:0] width
    );
        logic [CntBits-1:0] w;
        w = width;
        if (w == '0) begin
            w = 6'd1;
        end
        if (w >= 6'd32) begin
            return poly;
        end
        return poly << (6'd32 - w);
    endfunction

endpackage

// ----- hw/rtl/vwcrc_cfg.sv -----
// ---------------------------------------------------------------------------
// vwcrc_cfg
// Configuration registers; keeps the polynomial pre-aligned for the datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module vwcrc_cfg (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic                     cfg_addr,
    input  logic [31:0]              cfg_wr_data,
    output vwcrc_pkg::cfg_t          cfg
);
    import vwcrc_pkg::*;

    logic [CrcBits-1:0] poly_reg;
    logic [CntBits-1:0] width_reg;
    logic [CrcBits-1:0] aligned_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poly_reg    <= POLY_RESET;
            width_reg   <= WIDTH_RESET;
            aligned_reg <= POLY_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_POLYNOMIAL: begin
                    poly_reg    <= cfg_wr_data;
                    aligned_reg <= align_poly(cfg_wr_data, width_reg);
                end
                CFG_CRC_WIDTH: begin
                    width_reg   <= cfg_wr_data[CntBits-1:0];
                    aligned_reg <= align_poly(poly_reg, cfg_wr_data[CntBits-1:0]);
                end
                default: begin
                    poly_reg <= poly_reg;
                end
            endcase
        end
    end

    assign cfg.poly_aligned = aligned_reg;

endmodule

// ----- hw/rtl/vwcrc_update.sv -----
// ---------------------------------------------------------------------------
// vwcrc_update
// Bit-parallel XOR network that folds up to 32 data bits into the CRC.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module vwcrc_update (
    input  logic [31:0]              crc_in,
    input  vwcrc_pkg::item_t         item,
    input  vwcrc_pkg::cfg_t          cfg,
    output logic [31:0]              crc_out
);
    import vwcrc_pkg::*;

    logic [CntBits-1:0] n;
    logic [CrcBits-1:0] start;
    logic [CrcBits-1:0] data_top;
    logic [CrcBits-1:0] acc;

    always_comb begin
        n = (item.nbits > 6'd32) ? 6'd32 : item.nbits;
        start = item.first ? item.seed : crc_in;
        // Move the low n data bits to the top of the word, MSB first.
        if (n == '0) begin
            data_top = '0;
        end else if (n == 6'd32) begin
            data_top = item.data_word;
        end else begin
            data_top = item.data_word << (6'd32 - n);
        end
        acc = start ^ data_top;
        for (int i = 0; i < CrcBits; i++) begin
            if (CntBits'(i) < n) begin
                acc = {acc[CrcBits-2:0], 1'b0} ^ (acc[CrcBits-1] ? cfg.poly_aligned : '0);
            end
        end
        crc_out = acc;
    end

endmodule

// ----- hw/rtl/variable_width_crc_engine_unit.sv -----
// An input item is registered, then its CRC is written to the result register; 1 item per cycle
// sustained while m_tready stays high. The CRC state feeds back through a single XOR network
// between the input register and the result register, so each item makes one pass through it.
// Reset (aresetn low, synchronous) empties both stages, clears the CRC to zero and
// restores polynomial 0x04C11DB7 with width 32.
// ---------------------------------------------------------------------------
// variable_width_crc_engine_unit
// Programmable-width MSB-first CRC engine with stream input and output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "variable_width_crc_engine_unit_macros.svh"

module variable_width_crc_engine_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [31:0] cfg_wr_data,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // seed[31:0], data_word[63:32], nbits[69:64], zero pad
    input  logic        s_tuser,   // first[0]
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // crc_value[31:0]
);
    import vwcrc_pkg::*;

    cfg_t               cfg;
    item_t              in_item_reg;
    logic               in_vld_reg;
    logic               out_vld_reg;
    logic [CrcBits-1:0] crc_reg;
    logic [CrcBits-1:0] crc_next;
    logic               advance;

    vwcrc_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    vwcrc_update u_update (
        .crc_in  (crc_reg),
        .item    (in_item_reg),
        .cfg     (cfg),
        .crc_out (crc_next)
    );

    // The registered item moves on whenever the result register is free or drains.
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.first     <= s_tuser;
            in_item_reg.seed      <= s_tdata[31:0];
            in_item_reg.data_word <= s_tdata[63:32];
            in_item_reg.nbits     <= s_tdata[69:64];
        end
    end

    // The result register doubles as the running CRC state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
            crc_reg     <= '0;
        end else begin
            if (advance) begin
                out_vld_reg <= 1'b1;
                crc_reg     <= crc_next;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = crc_reg;

    `VWCRC_ASSERT_NEXT(a_advance_gives_result, aclk, aresetn, advance, m_tvalid)
    `VWCRC_ASSERT_NEXT(a_item_held_when_blocked, aclk, aresetn, in_vld_reg && !advance, in_vld_reg && $stable(in_item_reg))
    `VWCRC_ASSERT_SAME(a_backpressure_only_when_full, aclk, aresetn, !s_tready, in_vld_reg && m_tvalid && !m_tready)

endmodule
